>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/sds_pkg.sv
package sds_pkg;

    localparam int unsigned PAYLOAD_BYTES   = 120;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    // left-justified sample, five 7-bit slots
    localparam int unsigned JUST_W          = 35;

    localparam logic [7:0] SDS_SOX      = 8'hF0;
    localparam logic [7:0] SDS_NON_RT   = 8'h7E;
    localparam logic [7:0] SDS_DATA_PKT = 8'h02;
    localparam logic [7:0] SDS_EOX      = 8'hF7;

    localparam logic [5:0] SAMPLE_BITS_RST = 6'd16;
    localparam logic [5:0] BITS_MIN        = 6'd8;
    localparam logic [5:0] BITS_MAX        = 6'd32;
    localparam logic [6:0] DEVICE_ID_RST   = 7'd0;

    localparam logic [0:0] REG_SAMPLE_BITS = 1'b0;
    localparam logic [0:0] REG_DEVICE_ID   = 1'b1;

    // One accepted sample, classified by the front end.
    typedef struct packed {
        logic              hdr;      // packet opens with this sample
        logic [6:0]        dev;
        logic [6:0]        pk;
        logic [JUST_W-1:0] just;     // sample, left-justified
        logic [2:0]        mbytes;
        logic              close;    // packet closes after this sample
        logic              pad;      // zero run before the checksum
        logic [6:0]        pad_len;
        logic [6:0]        chk;      // checksum of the closing packet
    } sds_job_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [6:0] run_length;
        logic       packet_end;
        logic       last_of_run;
    } sds_result_t;

    // MIDI bytes per sample, ceil(bits/7)
    function automatic logic [2:0] mbytes_of(input logic [5:0] bits);
        logic [2:0] m;
        if (bits <= 6'd7) begin
            m = 3'd1;
        end else if (bits <= 6'd14) begin
            m = 3'd2;
        end else if (bits <= 6'd21) begin
            m = 3'd3;
        end else if (bits <= 6'd28) begin
            m = 3'd4;
        end else begin
            m = 3'd5;
        end
        return m;
    endfunction

endpackage

>>> rtl/sds_front.sv
`include "assert_macros.svh"

module sds_front import sds_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] sample_word,
    input  logic        last_sample,
    output sds_job_t    job,
    output logic        job_push,
    input  logic        queue_full
);

    logic [5:0] sample_bits_reg;
    logic [6:0] device_id_reg;
    logic       open_reg,  open_next;
    logic [7:0] bytes_reg, bytes_next;
    logic [6:0] chk_reg,   chk_next;
    logic [6:0] count_reg, count_next;

    logic [5:0]        bits_c;
    logic [5:0]        bits_up;
    logic [2:0]        wbytes;
    logic [2:0]        mb;
    logic [31:0]       masked;
    logic [31:0]       offset;
    logic [31:0]       val;
    logic [5:0]        lsh;
    logic [JUST_W-1:0] just;
    logic [6:0]        xr;
    logic [6:0]        base_chk;
    logic [7:0]        base_bytes;
    logic [7:0]        new_bytes;
    logic [7:0]        fit_next;
    logic [6:0]        new_chk;
    logic              close;

    assign s_ready  = !queue_full;
    assign job_push = s_valid && s_ready;

    always_comb begin
        if (sample_bits_reg < BITS_MIN) begin
            bits_c = BITS_MIN;
        end else if (sample_bits_reg > BITS_MAX) begin
            bits_c = BITS_MAX;
        end else begin
            bits_c = sample_bits_reg;
        end
        bits_up = bits_c + 6'd7;
        wbytes  = bits_up[5:3];
        mb      = mbytes_of(bits_c);

        case (wbytes)
            3'd1:    masked = {24'd0, sample_word[7:0]};
            3'd2:    masked = {16'd0, sample_word[15:0]};
            3'd3:    masked = {8'd0,  sample_word[23:0]};
            default: masked = sample_word;
        endcase
        // half-scale offset turns two's complement into offset binary for samples wider than 8 bits
        offset = (wbytes > 3'd1) ? (32'd1 << (bits_c - 6'd1)) : 32'd0;
        val    = masked + offset;
        lsh    = 6'(JUST_W) - bits_c;
        just   = {3'd0, val} << lsh;
        // slots beyond the sample's last MIDI byte are zero
        xr     = just[34:28] ^ just[27:21] ^ just[20:14] ^ just[13:7] ^ just[6:0];

        base_chk   = open_reg ? chk_reg
                   : (SDS_NON_RT[6:0] ^ device_id_reg ^ SDS_DATA_PKT[6:0] ^ count_reg);
        base_bytes = open_reg ? bytes_reg : 8'd0;
        new_bytes  = base_bytes + {5'd0, mb};
        fit_next   = new_bytes + {5'd0, mb};
        new_chk    = base_chk ^ xr;
        close      = last_sample || (fit_next > 8'(PAYLOAD_BYTES));

        job.hdr     = !open_reg;
        job.dev     = device_id_reg;
        job.pk      = count_reg;
        job.just    = just;
        job.mbytes  = mb;
        job.close   = close;
        job.pad     = new_bytes < 8'(PAYLOAD_BYTES);
        job.pad_len = 7'(8'(PAYLOAD_BYTES) - new_bytes);
        job.chk     = new_chk;

        open_next  = open_reg;
        bytes_next = bytes_reg;
        chk_next   = chk_reg;
        count_next = count_reg;
        if (job_push) begin
            if (close) begin
                open_next  = 1'b0;
                bytes_next = 8'd0;
                chk_next   = 7'd0;
                count_next = last_sample ? 7'd0 : count_reg + 7'd1;
            end else begin
                open_next  = 1'b1;
                bytes_next = new_bytes;
                chk_next   = new_chk;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_bits_reg <= SAMPLE_BITS_RST;
            device_id_reg   <= DEVICE_ID_RST;
            open_reg        <= 1'b0;
            bytes_reg       <= 8'd0;
            chk_reg         <= 7'd0;
            count_reg       <= 7'd0;
        end else begin
            open_reg  <= open_next;
            bytes_reg <= bytes_next;
            chk_reg   <= chk_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SAMPLE_BITS: sample_bits_reg <= cfg_wdata[5:0];
                    REG_DEVICE_ID:   device_id_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    `ASSERT_NXT(a_close_ends_packet, aclk, aresetn, job_push && job.close, !open_reg)
    `ASSERT_IMP(a_closed_is_clear, aclk, aresetn, !open_reg, bytes_reg == 8'd0 && chk_reg == 7'd0)

endmodule

>>> rtl/sds_queue.sv
`include "assert_macros.svh"

module sds_queue import sds_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  sds_job_t push_job,
    output logic     full,
    input  logic     pop,
    output sds_job_t head,
    output logic     head_valid
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sds_job_t        slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !full)

endmodule

>>> rtl/sds_back.sv
`include "assert_macros.svh"

module sds_back import sds_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sds_job_t    job,
    input  logic        job_valid,
    output logic        job_pop,
    output sds_result_t res,
    output logic        m_valid,
    input  logic        m_ready
);

    typedef enum logic [2:0] {
        PH_START,
        PH_HDR,
        PH_DATA,
        PH_PAD,
        PH_CHK,
        PH_END
    } phase_t;

    phase_t      phase_reg, phase_next, eff_phase;
    logic [2:0]  idx_reg,   idx_next,   eff_idx;
    logic        m_valid_reg;
    sds_result_t res_reg, res_c;
    logic [6:0]  slice;
    logic        done;
    logic        fire;

    assign m_valid = m_valid_reg;
    assign res     = res_reg;
    assign fire    = job_valid && (!m_valid_reg || m_ready);
    assign job_pop = fire && done;

    always_comb begin
        eff_phase = (phase_reg == PH_START) ? (job.hdr ? PH_HDR : PH_DATA) : phase_reg;
        eff_idx   = (phase_reg == PH_START) ? 3'd0 : idx_reg;

        case (eff_idx)
            3'd0:    slice = job.just[34:28];
            3'd1:    slice = job.just[27:21];
            3'd2:    slice = job.just[20:14];
            3'd3:    slice = job.just[13:7];
            default: slice = job.just[6:0];
        endcase

        res_c.out_byte    = 8'd0;
        res_c.run_length  = 7'd1;
        res_c.packet_end  = 1'b0;
        res_c.last_of_run = 1'b0;
        phase_next        = eff_phase;
        idx_next          = eff_idx;
        done              = 1'b0;

        case (eff_phase)
            PH_HDR: begin
                case (eff_idx)
                    3'd0:    res_c.out_byte = SDS_SOX;
                    3'd1:    res_c.out_byte = SDS_NON_RT;
                    3'd2:    res_c.out_byte = {1'b0, job.dev};
                    3'd3:    res_c.out_byte = SDS_DATA_PKT;
                    default: res_c.out_byte = {1'b0, job.pk};
                endcase
                if (eff_idx == 3'd4) begin
                    phase_next = PH_DATA;
                    idx_next   = 3'd0;
                end else begin
                    idx_next = eff_idx + 3'd1;
                end
            end
            PH_DATA: begin
                res_c.out_byte = {1'b0, slice};
                if (eff_idx == job.mbytes - 3'd1) begin
                    idx_next = 3'd0;
                    if (job.close) begin
                        phase_next = job.pad ? PH_PAD : PH_CHK;
                    end else begin
                        res_c.last_of_run = 1'b1;
                        done              = 1'b1;
                        phase_next        = PH_START;
                    end
                end else begin
                    idx_next = eff_idx + 3'd1;
                end
            end
            PH_PAD: begin
                res_c.run_length = job.pad_len;
                phase_next       = PH_CHK;
            end
            PH_CHK: begin
                res_c.out_byte = {1'b0, job.chk};
                phase_next     = PH_END;
            end
            PH_END: begin
                res_c.out_byte    = SDS_EOX;
                res_c.packet_end  = 1'b1;
                res_c.last_of_run = 1'b1;
                done              = 1'b1;
                phase_next        = PH_START;
            end
            default: begin
                phase_next = PH_START;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            idx_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            m_valid_reg <= 1'b1;
            res_reg     <= res_c;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    `ASSERT_IMP(a_end_has_last, aclk, aresetn, m_valid_reg && res_reg.packet_end,
                res_reg.last_of_run)
    `ASSERT_IMP(a_tail_needs_close, aclk, aresetn,
                phase_reg == PH_PAD || phase_reg == PH_CHK || phase_reg == PH_END,
                job_valid && job.close)

endmodule

>>> rtl/sds_sample_packet_encoder.sv
// Sample Dump Standard data-packet encoder. Each accepted sample (s_tdata,
// s_tlast marks the last sample of a dump) becomes 2 to 5 MIDI data bytes,
// ceil(sample_bits/7), wrapped into packets F0 7E dev 02 num, 120 data bytes,
// checksum, F7. Results leave one per clock while m_tready is high and a job is
// queued: a packet's first sample adds the five header bytes, a closing sample adds
// checksum and F7 plus one result for the zero-padding run (carried as a single
// result with run_length) when the packet is short. The output byte sequencer sets
// the pace; the front end takes a sample every clock while its QUEUE_DEPTH-entry
// job queue has room. Configuration writes are meant for idle periods only.
module sds_sample_packet_encoder import sds_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [14:8] run_length, [15] zero
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] packet_end
);

    sds_job_t    push_job, head_job;
    logic        job_push, queue_full, job_pop, head_valid;
    sds_result_t res;

    sds_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .sample_word (s_tdata),
        .last_sample (s_tlast),
        .job         (push_job),
        .job_push    (job_push),
        .queue_full  (queue_full)
    );

    sds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (job_pop),
        .head       (head_job),
        .head_valid (head_valid)
    );

    sds_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (head_job),
        .job_valid (head_valid),
        .job_pop   (job_pop),
        .res       (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready)
    );

    assign m_tdata = {1'b0, res.run_length, res.out_byte};
    assign m_tlast = res.last_of_run;
    assign m_tuser = res.packet_end;

endmodule
